// ===== rtl/escaped_frame_receiver_top_defines.svh =====
// ---------------------------------------------------------------------------
// Escaped frame receiver assertion macros
// Shared concurrent assertion helpers, empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_RECEIVER_TOP_DEFINES_SVH
`define ESCAPED_FRAME_RECEIVER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define EFR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("efr assertion failed");
`define EFR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("efr implication failed");
`else
`define EFR_ASSERT(lbl, prop)
`define EFR_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

// ===== rtl/efr_pkg.sv =====
// ---------------------------------------------------------------------------
// Escaped frame receiver package
// Shared types, codes and the address table of the frame receiver.
// ---------------------------------------------------------------------------
package efr_pkg;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ADDR,
    PH_BODY,
    PH_DRAIN
  } efr_phase_t;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_CSUM_ERR = 2'd1;
  localparam logic [1:0] STATUS_ADDR_ERR = 2'd2;

  localparam logic CFG_END_MARKER    = 1'b0;
  localparam logic CFG_ESCAPE_MARKER = 1'b1;

  localparam logic [7:0] END_MARKER_RST    = 8'd193;
  localparam logic [7:0] ESCAPE_MARKER_RST = 8'd125;
  localparam logic [7:0] ESC_FLIP          = 8'h20;
  localparam logic [1:0] DRAIN_BEATS       = 2'd3;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic [2:0] expected_slot;
    logic [7:0] capacity;
  } efr_in_item_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic       frame_done;
    logic [1:0] status;
    logic [7:0] stored_count;
  } efr_out_item_t;

  typedef struct packed {
    logic          valid;
    efr_out_item_t item;
  } efr_result_t;

  typedef struct packed {
    logic [7:0] end_marker;
    logic [7:0] escape_marker;
  } efr_cfg_t;

  function automatic logic [7:0] addr_lookup(input logic [2:0] slot);
    logic [7:0] addr;
    unique case (slot)
      3'd0: addr = 8'h0e;
      3'd1: addr = 8'h20;
      3'd2: addr = 8'h42;
      3'd3: addr = 8'h64;
      3'd4: addr = 8'h86;
      3'd5: addr = 8'ha8;
      3'd6: addr = 8'hca;
      3'd7: addr = 8'hec;
      default: addr = 8'h0e;
    endcase
    return addr;
  endfunction

endpackage

// ===== rtl/efr_in_if.sv =====
// ---------------------------------------------------------------------------
// Escaped frame receiver input channel
// Valid/ready channel carrying one received line byte per beat.
// ---------------------------------------------------------------------------
interface efr_in_if
  import efr_pkg::*;
();
  logic         valid;
  logic         ready;
  efr_in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/efr_out_if.sv =====
// ---------------------------------------------------------------------------
// Escaped frame receiver result channel
// Valid/ready channel carrying one data or frame status result per beat.
// ---------------------------------------------------------------------------
interface efr_out_if
  import efr_pkg::*;
();
  logic          valid;
  logic          ready;
  efr_out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/efr_cfg.sv =====
// ---------------------------------------------------------------------------
// Escaped frame receiver configuration registers
// Holds the end marker and escape marker written through the config port.
// ---------------------------------------------------------------------------
module efr_cfg
  import efr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata,
  output efr_cfg_t   cfg
);

  logic [7:0] end_marker_r;
  logic [7:0] escape_marker_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_marker_r    <= END_MARKER_RST;
      escape_marker_r <= ESCAPE_MARKER_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_END_MARKER:    end_marker_r    <= cfg_wdata;
        CFG_ESCAPE_MARKER: escape_marker_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg.end_marker    = end_marker_r;
  assign cfg.escape_marker = escape_marker_r;

endmodule

// ===== rtl/efr_core.sv =====
// ---------------------------------------------------------------------------
// Escaped frame receiver deframer
// Per-beat frame state machine: address check, unescaping, checksum, drain.
// ---------------------------------------------------------------------------
`include "escaped_frame_receiver_top_defines.svh"

module efr_core
  import efr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  efr_cfg_t     cfg,
  input  logic         fire,
  input  efr_in_item_t beat,
  output efr_result_t  res
);

  efr_phase_t phase_r, phase_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] stored_r, stored_nxt;
  logic [7:0] room_r, room_nxt;
  logic [2:0] slot_r, slot_nxt;
  logic [1:0] drain_r, drain_nxt;
  logic       esc_r, esc_nxt;
  logic [1:0] drain_dec;
  logic [7:0] sum_add;
  logic       addr_ok;

  assign drain_dec = drain_r - 2'd1;
  assign sum_add   = sum_r + beat.rx_byte;
  assign addr_ok   = (beat.rx_byte == addr_lookup(slot_r));

  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      unique case (phase_r)
        PH_ADDR: phase_nxt = addr_ok ? PH_BODY : PH_DRAIN;
        PH_DRAIN: begin
          if (drain_dec == 2'd0) begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_BODY: begin
          if (!esc_r && (beat.rx_byte == cfg.end_marker)) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: phase_nxt = PH_ADDR;
      endcase
    end
  end

  always_comb begin
    sum_nxt    = sum_r;
    stored_nxt = stored_r;
    room_nxt   = room_r;
    slot_nxt   = slot_r;
    drain_nxt  = drain_r;
    esc_nxt    = esc_r;
    res        = '0;
    if (fire) begin
      unique case (phase_r)
        PH_ADDR: begin
          if (!addr_ok) begin
            drain_nxt            = DRAIN_BEATS;
            res.valid            = 1'b1;
            res.item.frame_done  = 1'b1;
            res.item.status      = STATUS_ADDR_ERR;
          end else begin
            sum_nxt    = beat.rx_byte;
            stored_nxt = '0;
            esc_nxt    = 1'b0;
          end
        end
        PH_DRAIN: drain_nxt = drain_dec;
        PH_BODY: begin
          if (esc_r) begin
            esc_nxt             = 1'b0;
            stored_nxt          = stored_r + 8'd1;
            room_nxt            = room_r - 8'd1;
            res.valid           = 1'b1;
            res.item.data_valid = 1'b1;
            res.item.data_byte  = beat.rx_byte ^ ESC_FLIP;
          end else if (beat.rx_byte == cfg.end_marker) begin
            res.valid             = 1'b1;
            res.item.frame_done   = 1'b1;
            res.item.status       = (sum_r != 8'd0) ? STATUS_CSUM_ERR : STATUS_OK;
            res.item.stored_count = stored_r;
          end else begin
            sum_nxt = sum_add;
            if (room_r != 8'd0) begin
              if (beat.rx_byte == cfg.escape_marker) begin
                esc_nxt = 1'b1;
              end else begin
                stored_nxt          = stored_r + 8'd1;
                room_nxt            = room_r - 8'd1;
                res.valid           = 1'b1;
                res.item.data_valid = 1'b1;
                res.item.data_byte  = beat.rx_byte;
              end
            end
          end
        end
        default: begin
          slot_nxt   = beat.expected_slot;
          room_nxt   = beat.capacity;
          stored_nxt = '0;
          sum_nxt    = '0;
          esc_nxt    = 1'b0;
          drain_nxt  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      sum_r    <= '0;
      stored_r <= '0;
      room_r   <= '0;
      slot_r   <= '0;
      drain_r  <= '0;
      esc_r    <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      sum_r    <= sum_nxt;
      stored_r <= stored_nxt;
      room_r   <= room_nxt;
      slot_r   <= slot_nxt;
      drain_r  <= drain_nxt;
      esc_r    <= esc_nxt;
    end
  end

  // A pending escape can only exist inside a frame body.
  `EFR_ASSERT_IMP(a_esc_in_body, esc_r, phase_r == PH_BODY)
  // The drain phase always has beats left to drop.
  `EFR_ASSERT_IMP(a_drain_nonzero, phase_r == PH_DRAIN, drain_r != 2'd0)
  // A result is either a data byte or a frame close, never both.
  `EFR_ASSERT_IMP(a_res_kind, res.valid, res.item.data_valid != res.item.frame_done)

endmodule

// ===== rtl/efr_out.sv =====
// ---------------------------------------------------------------------------
// Escaped frame receiver result stage
// Output register with one skid entry; input beats keep flowing under stall until it fills.
// ---------------------------------------------------------------------------
`include "escaped_frame_receiver_top_defines.svh"

module efr_out
  import efr_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  efr_result_t   res,
  output logic          accept_ok,
  output logic          out_valid,
  input  logic          out_ready,
  output efr_out_item_t out_item
);

  logic          out_valid_r;
  efr_out_item_t out_data_r;
  logic          skid_valid_r;
  efr_out_item_t skid_data_r;
  logic          drain_ok;

  assign drain_ok  = !out_valid_r || out_ready;
  assign accept_ok = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ready) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (drain_ok) begin
      out_valid_r <= res.valid;
    end else if (res.valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_ready) begin
        out_data_r <= skid_data_r;
      end
    end else if (drain_ok) begin
      out_data_r <= res.item;
    end else if (res.valid) begin
      skid_data_r <= res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_data_r;

  // The skid entry is only used behind a full output register.
  `EFR_ASSERT_IMP(a_skid_behind_out, skid_valid_r, out_valid_r)
  // No new result arrives while the skid entry is occupied.
  `EFR_ASSERT_IMP(a_no_push_on_skid, skid_valid_r, !res.valid)
  // The skid entry fills only when the output register was stalled.
  `EFR_ASSERT(a_skid_on_stall, $rose(skid_valid_r) |-> $past(out_valid_r && !out_ready))

endmodule

// ===== rtl/escaped_frame_receiver_top.sv =====
// ---------------------------------------------------------------------------
// Escaped frame receiver
// Deframes byte-stuffed frames, checks address and checksum, emits results.
// ---------------------------------------------------------------------------
// Line bytes enter on in_bus, one per beat, together with the slot and
// capacity that are latched on a frame's first byte. Each beat produces zero
// or one result on out_bus: an unescaped body byte, or a frame close with its
// status and the number of stored bytes.
// A result is registered in the output register, or in the skid entry while
// out_bus stalls; the block takes one beat per cycle while in_bus is ready.
// The end and escape markers are written by the user through cfg_wr_en,
// cfg_index and cfg_wdata only while the block is idle; it does not enforce this.
// A synchronous reset restores the default markers and waits for a new frame.
// When out_bus stalls, one further result is held in a skid entry and in_bus
// then deasserts ready until the stall clears.
// ---------------------------------------------------------------------------
module escaped_frame_receiver_top
  import efr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  efr_in_if.sink     in_bus,
  efr_out_if.source  out_bus,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata
);

  efr_cfg_t    cfg;
  efr_result_t res;
  logic        accept_ok;
  logic        fire;

  assign in_bus.ready = accept_ok;
  assign fire         = in_bus.valid && accept_ok;

  efr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  efr_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (fire),
    .beat  (in_bus.payload),
    .res   (res)
  );

  efr_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .accept_ok (accept_ok),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_item  (out_bus.payload)
  );

endmodule
